/* hw/rtl/toy_word_machine_executor_defines.svh */
// Assertion macros shared by the toy word machine executor RTL.
// Stand-alone header; the files that check behavior include it.
`ifndef TOY_WORD_MACHINE_EXECUTOR_DEFINES_SVH
`define TOY_WORD_MACHINE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TWE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TWE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/twe_pkg.sv */
// Package of the toy word machine executor: codes, characters and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package twe_pkg;

   localparam int ADDR_CALC_W = 8;
   localparam int CARD_WORDS  = 10;

   typedef enum logic [1:0] {
      REQ_NEW  = 2'd0,
      REQ_PROG = 2'd1,
      REQ_STEP = 2'd2,
      REQ_DATA = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_RUN  = 2'd0,
      MODE_LOAD = 2'd1,
      MODE_WAIT = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   localparam logic [3:0] ST_EXEC    = 4'd0;
   localparam logic [3:0] ST_WANT    = 4'd1;
   localparam logic [3:0] ST_PRINT   = 4'd2;
   localparam logic [3:0] ST_TERM    = 4'd3;
   localparam logic [3:0] ST_END     = 4'd4;
   localparam logic [3:0] ST_IDLE    = 4'd5;
   localparam logic [3:0] ST_BADADDR = 4'd6;
   localparam logic [3:0] ST_STORED  = 4'd7;
   localparam logic [3:0] ST_FULL    = 4'd8;
   localparam logic [3:0] ST_DATA    = 4'd9;
   localparam logic [3:0] ST_RESET   = 4'd10;
   localparam logic [3:0] ST_UNEXP   = 4'd11;

   localparam logic [7:0] CH_G = 8'h47;
   localparam logic [7:0] CH_D = 8'h44;
   localparam logic [7:0] CH_P = 8'h50;
   localparam logic [7:0] CH_H = 8'h48;
   localparam logic [7:0] CH_L = 8'h4C;
   localparam logic [7:0] CH_R = 8'h52;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_C = 8'h43;
   localparam logic [7:0] CH_B = 8'h42;
   localparam logic [7:0] CH_T = 8'h54;
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;

   typedef enum logic [1:0] {
      EX_SINGLE = 2'd0,
      EX_OPER   = 2'd1,
      EX_PRINT  = 2'd2
   } ex_kind_type;

   typedef struct packed {
      logic latch_req;
      logic do_decide;
      logic do_fetch;
      logic do_exec;
      logic do_oper;
      logic print_rd;
      logic print_out;
   } cmd_type;

   typedef struct packed {
      logic        decide_reads;
      ex_kind_type ex_kind;
      logic        print_last;
      logic        out_free;
   } stat_type;

endpackage

`default_nettype wire

/* hw/rtl/twe_channels.sv */
// Valid/ready channel interfaces of the toy word machine executor:
// the request channel and the response channel. No dependencies.
`default_nettype none

interface twe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] word_in;
   logic        card_end;

   modport source (output valid, output req_type, output word_in, output card_end,
                   input ready);
   modport sink (input valid, input req_type, input word_in, input card_end,
                 output ready);
endinterface

interface twe_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] out_word;
   logic [3:0]  byte_mask;
   logic        last;

   modport source (output valid, output status, output out_word, output byte_mask,
                   output last, input ready);
   modport sink (input valid, input status, input out_word, input byte_mask,
                 input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/twe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module twe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/twe_ctrl.sv */
// Controller state machine of the toy word machine executor.
// Depends on twe_pkg for the command and status structs.
`default_nettype none

module twe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  twe_pkg::stat_type stat,
   output twe_pkg::cmd_type  cmd
);
   import twe_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECIDE = 7'b0000010,
      S_FETCH  = 7'b0000100,
      S_EXEC   = 7'b0001000,
      S_OPER   = 7'b0010000,
      S_PRT_RD = 7'b0100000,
      S_PRT_WR = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // A step that runs only starts a fetch, so it needs no free result slot.
            if (stat.decide_reads) begin
               cmd.do_decide = 1'b1;
               state_in      = S_FETCH;
            end else if (stat.out_free) begin
               cmd.do_decide = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FETCH: begin
            cmd.do_fetch = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.ex_kind)
               EX_OPER: begin
                  cmd.do_exec = 1'b1;
                  state_in    = S_OPER;
               end
               EX_PRINT: begin
                  cmd.do_exec = 1'b1;
                  state_in    = S_PRT_RD;
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.do_exec = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
            endcase
         end
         S_OPER: begin
            if (stat.out_free) begin
               cmd.do_oper = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_PRT_RD: begin
            cmd.print_rd = 1'b1;
            state_in     = S_PRT_WR;
         end
         S_PRT_WR: begin
            if (stat.out_free) begin
               cmd.print_out = 1'b1;
               state_in      = stat.print_last ? S_IDLE : S_PRT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/twe_dp.sv */
// Datapath of the toy word machine executor: machine registers, word memory
// with per-word valid flags, decode and the result register.
// Depends on twe_pkg and twe_ram.
`default_nettype none

module twe_dp #(
   parameter int MEM_WORDS = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  twe_pkg::cmd_type  cmd,
   output twe_pkg::stat_type stat,
   input  logic [1:0]        req_type,
   input  logic [31:0]       word_in,
   input  logic              card_end,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [3:0]        rsp_status,
   output logic [31:0]       rsp_word,
   output logic [3:0]        rsp_mask,
   output logic              rsp_last
);
   import twe_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int CW = $clog2(MEM_WORDS + 1);
   localparam logic [CW-1:0]          IC_LIM  = CW'(MEM_WORDS);
   localparam logic [ADDR_CALC_W-1:0] MEM_LIM = ADDR_CALC_W'(MEM_WORDS);
   localparam logic [ADDR_CALC_W-1:0] CARD_N  = ADDR_CALC_W'(CARD_WORDS);

   // Returns {is_digit, value} for one ASCII character.
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      logic       ok;
      d  = c - CH_0;
      ok = (c >= CH_0) && (c <= CH_9);
      return {ok, d[3:0]};
   endfunction

   function automatic logic [ADDR_CALC_W-1:0] times_ten(input logic [3:0] v);
      return ADDR_CALC_W'({v, 3'b000}) + ADDR_CALC_W'({v, 1'b0});
   endfunction

   // Latched item
   logic [1:0]  rq_type_ff, rq_type_in;
   logic [31:0] rq_word_ff, rq_word_in;
   logic        rq_end_ff, rq_end_in;

   // Machine state
   logic [31:0]          gp_ff, gp_in;
   logic                 eq_ff, eq_in;
   logic [CW-1:0]        ic_ff, ic_in;
   mode_type             mode_ff, mode_in;
   logic [3:0]           cblk_ff, cblk_in;
   logic [3:0]           coff_ff, coff_in;
   logic [MEM_WORDS-1:0] vld_ff, vld_in;

   // Working registers
   logic [31:0]   ir_ff, ir_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] p_addr_ff, p_addr_in;
   logic [3:0]    p_cnt_ff, p_cnt_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_status_ff, out_status_in;
   logic [31:0] out_word_ff, out_word_in;
   logic [3:0]  out_mask_ff, out_mask_in;
   logic        out_last_ff, out_last_in;

   // Memory port
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data, mem_word;

   // Decode
   logic [7:0]             op0, op1;
   logic [4:0]             dg1, dg2;
   logic [ADDR_CALC_W-1:0] blk_base, op_addr, card_addr;
   logic                   blk_ok, op_ok, data_ok;
   logic                   is_zero, is_h, is_gd, is_pd, is_lr, is_sr, is_cr, is_bt;
   logic [CW-1:0]          eff_ic;
   logic                   step_go, out_free;
   logic [3:0]             coff_next;

   logic        load_out;
   logic [3:0]  o_status;
   logic [31:0] o_word;
   logic        o_last;

   twe_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A word never written since the last job start reads as zero.
   assign mem_word = rd_vld_ff ? rd_data : 32'd0;

   assign op0      = ir_ff[31:24];
   assign op1      = ir_ff[23:16];
   assign dg1      = digit_of(ir_ff[15:8]);
   assign dg2      = digit_of(ir_ff[7:0]);
   assign blk_base = times_ten(dg1[3:0]);
   assign op_addr  = blk_base + ADDR_CALC_W'(dg2[3:0]);
   assign blk_ok   = dg1[4] && (blk_base + CARD_N <= MEM_LIM);
   assign op_ok    = dg1[4] && dg2[4] && (op_addr < MEM_LIM);

   assign is_zero = (op0 == 8'h00);
   assign is_h    = (op0 == CH_H);
   assign is_gd   = (op0 == CH_G) && (op1 == CH_D);
   assign is_pd   = (op0 == CH_P) && (op1 == CH_D);
   assign is_lr   = (op0 == CH_L) && (op1 == CH_R);
   assign is_sr   = (op0 == CH_S) && (op1 == CH_R);
   assign is_cr   = (op0 == CH_C) && (op1 == CH_R);
   assign is_bt   = (op0 == CH_B) && (op1 == CH_T);

   assign eff_ic    = (mode_ff == MODE_LOAD) ? '0 : ic_ff;
   assign step_go   = ((mode_ff == MODE_RUN) || (mode_ff == MODE_LOAD)) && (eff_ic < IC_LIM);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign card_addr = times_ten(cblk_ff) + ADDR_CALC_W'(coff_ff);
   assign coff_next = coff_ff + 4'd1;
   assign data_ok   = (mode_ff == MODE_WAIT) && (ADDR_CALC_W'(coff_ff) < CARD_N) &&
                      (card_addr < MEM_LIM);

   always_comb begin
      stat.decide_reads = (rq_type_ff == REQ_STEP) && step_go;
      stat.out_free     = out_free;
      stat.print_last   = (p_cnt_ff == 4'(CARD_WORDS - 1));
      if (is_pd && blk_ok) begin
         stat.ex_kind = EX_PRINT;
      end else if ((is_lr || is_cr) && op_ok) begin
         stat.ex_kind = EX_OPER;
      end else begin
         stat.ex_kind = EX_SINGLE;
      end
   end

   always_comb begin
      rq_type_in = rq_type_ff;
      rq_word_in = rq_word_ff;
      rq_end_in  = rq_end_ff;
      gp_in      = gp_ff;
      eq_in      = eq_ff;
      ic_in      = ic_ff;
      mode_in    = mode_ff;
      cblk_in    = cblk_ff;
      coff_in    = coff_ff;
      vld_in     = vld_ff;
      ir_in      = ir_ff;
      rd_vld_in  = rd_vld_ff;
      p_addr_in  = p_addr_ff;
      p_cnt_in   = p_cnt_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      load_out   = 1'b0;
      o_status   = ST_EXEC;
      o_word     = '0;
      o_last     = 1'b1;

      if (cmd.latch_req) begin
         rq_type_in = req_type;
         rq_word_in = word_in;
         rq_end_in  = card_end;
      end

      if (cmd.do_decide) begin
         unique case (rq_type_ff)
            REQ_NEW: begin
               vld_in   = '0;
               gp_in    = '0;
               eq_in    = 1'b1;
               ic_in    = '0;
               cblk_in  = '0;
               coff_in  = '0;
               mode_in  = MODE_LOAD;
               load_out = 1'b1;
               o_status = ST_RESET;
            end
            REQ_PROG: begin
               mode_in  = MODE_LOAD;
               load_out = 1'b1;
               if (ic_ff >= IC_LIM) begin
                  o_status = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = ic_ff[AW-1:0];
                  wr_data  = rq_word_ff;
                  ic_in    = ic_ff + CW'(1);
                  o_status = ST_STORED;
               end
            end
            REQ_STEP: begin
               // The first step after loading restarts the program at word zero.
               if (mode_ff == MODE_LOAD) begin
                  ic_in   = '0;
                  mode_in = MODE_RUN;
               end
               if (mode_ff == MODE_WAIT) begin
                  load_out = 1'b1;
                  o_status = ST_WANT;
               end else if (mode_ff == MODE_STOP) begin
                  load_out = 1'b1;
                  o_status = ST_IDLE;
               end else if (!step_go) begin
                  mode_in  = MODE_STOP;
                  load_out = 1'b1;
                  o_status = ST_END;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = eff_ic[AW-1:0];
               end
            end
            default: begin
               load_out = 1'b1;
               if (data_ok) begin
                  wr_en    = 1'b1;
                  wr_addr  = card_addr[AW-1:0];
                  wr_data  = rq_word_ff;
                  coff_in  = coff_next;
                  if (rq_end_ff || (ADDR_CALC_W'(coff_next) >= CARD_N)) begin
                     mode_in = MODE_RUN;
                  end
                  o_status = ST_DATA;
               end else begin
                  o_status = ST_UNEXP;
               end
            end
         endcase
      end

      if (cmd.do_fetch) begin
         ir_in = mem_word;
      end

      if (cmd.do_exec) begin
         if (is_zero) begin
            mode_in  = MODE_STOP;
            load_out = 1'b1;
            o_status = ST_END;
         end else begin
            ic_in = ic_ff + CW'(1);
            if (is_h) begin
               mode_in  = MODE_STOP;
               load_out = 1'b1;
               o_status = ST_TERM;
            end else if (is_gd || is_pd) begin
               if (!blk_ok) begin
                  mode_in  = MODE_STOP;
                  load_out = 1'b1;
                  o_status = ST_BADADDR;
               end else if (is_gd) begin
                  cblk_in  = dg1[3:0];
                  coff_in  = '0;
                  mode_in  = MODE_WAIT;
                  load_out = 1'b1;
                  o_status = ST_WANT;
               end else begin
                  p_addr_in = blk_base[AW-1:0];
                  p_cnt_in  = '0;
               end
            end else if (is_lr || is_sr || is_cr || is_bt) begin
               if (!op_ok) begin
                  mode_in  = MODE_STOP;
                  load_out = 1'b1;
                  o_status = ST_BADADDR;
               end else if (is_lr || is_cr) begin
                  rd_en   = 1'b1;
                  rd_addr = op_addr[AW-1:0];
               end else begin
                  if (is_sr) begin
                     wr_en   = 1'b1;
                     wr_addr = op_addr[AW-1:0];
                     wr_data = gp_ff;
                  end else if (eq_ff) begin
                     ic_in = op_addr[CW-1:0];
                  end
                  load_out = 1'b1;
                  o_status = ST_EXEC;
               end
            end else begin
               // Unknown opcodes run as no-ops.
               load_out = 1'b1;
               o_status = ST_EXEC;
            end
         end
      end

      if (cmd.do_oper) begin
         if (is_lr) begin
            gp_in = mem_word;
         end else begin
            eq_in = (mem_word == gp_ff);
         end
         load_out = 1'b1;
         o_status = ST_EXEC;
      end

      if (cmd.print_rd) begin
         rd_en   = 1'b1;
         rd_addr = p_addr_ff;
      end

      if (cmd.print_out) begin
         load_out  = 1'b1;
         o_status  = ST_PRINT;
         o_word    = mem_word;
         o_last    = (p_cnt_ff == 4'(CARD_WORDS - 1));
         p_addr_in = p_addr_ff + AW'(1);
         p_cnt_in  = p_cnt_ff + 4'd1;
      end

      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_vld_in = vld_ff[rd_addr];
      end

      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_word_in   = out_word_ff;
      out_mask_in   = out_mask_ff;
      out_last_in   = out_last_ff;
      if (load_out) begin
         out_valid_in  = 1'b1;
         out_status_in = o_status;
         out_word_in   = o_word;
         out_mask_in   = {|o_word[31:24], |o_word[23:16], |o_word[15:8], |o_word[7:0]};
         out_last_in   = o_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff        <= '0;
         eq_ff        <= 1'b1;
         ic_ff        <= '0;
         mode_ff      <= MODE_RUN;
         cblk_ff      <= '0;
         coff_ff      <= '0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         gp_ff        <= gp_in;
         eq_ff        <= eq_in;
         ic_ff        <= ic_in;
         mode_ff      <= mode_in;
         cblk_ff      <= cblk_in;
         coff_ff      <= coff_in;
         vld_ff       <= vld_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_type_ff    <= rq_type_in;
      rq_word_ff    <= rq_word_in;
      rq_end_ff     <= rq_end_in;
      ir_ff         <= ir_in;
      p_addr_ff     <= p_addr_in;
      p_cnt_ff      <= p_cnt_in;
      out_status_ff <= out_status_in;
      out_word_ff   <= out_word_in;
      out_mask_ff   <= out_mask_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_word   = out_word_ff;
   assign rsp_mask   = out_mask_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/toy_word_machine_executor.sv */
// Toy word machine executor, top level: controller plus datapath.
// Depends on twe_pkg, twe_channels, twe_ram, twe_ctrl, twe_dp and the defines header.
//
// Usage: items arrive on req_bus (valid/ready) with a request type, a four-character
// word and a card-end flag; results leave on rsp_bus (valid/ready) with a status,
// an output word, its nonzero-character mask and a last flag on the final result.
// One item is worked at a time. New-job, program-word and data-card items, and steps
// that fetch nothing, load their result register from the decide state; a step that
// fetches passes the decide, fetch and execute states, and LR and CR add an operand
// state for a second memory read. A PD step then alternates a print-read and a
// print-write state for each printed word, since every memory read has a registered output.
// The next item is accepted in the cycle after its predecessor's last result is
// loaded, even while that result still waits in the output register.
// If the receiver stalls, the result is held and work stops at the next result.
// Reset (synchronous, active high) empties the result register and restores the
// machine registers; memory words read as zero through per-word valid flags, so
// no clearing pass is needed and items are accepted right after reset.
`default_nettype none
`include "toy_word_machine_executor_defines.svh"

module toy_word_machine_executor #(
   parameter int MEM_WORDS = 100
) (
   input  logic      clock,
   input  logic      reset,
   twe_req_if.sink   req_bus,
   twe_rsp_if.source rsp_bus
);
   import twe_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic req_fire;
   logic rsp_mid_burst;
   logic rsp_plain;
   logic rsp_plain_empty;

   twe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   twe_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_bus.req_type),
      .word_in    (req_bus.word_in),
      .card_end   (req_bus.card_end),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_status (rsp_bus.status),
      .rsp_word   (rsp_bus.out_word),
      .rsp_mask   (rsp_bus.byte_mask),
      .rsp_last   (rsp_bus.last)
   );

   assign req_fire        = req_bus.valid && req_bus.ready;
   assign rsp_mid_burst   = rsp_bus.valid && !rsp_bus.last;
   assign rsp_plain       = rsp_bus.valid && (rsp_bus.status != ST_PRINT);
   assign rsp_plain_empty = (rsp_bus.out_word == 32'd0) && (rsp_bus.byte_mask == 4'd0);

   `TWE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_bus.ready, "accept while busy")
   `TWE_ASSERT_NOW(a_burst_blocks, clock, reset, rsp_mid_burst, !req_bus.ready, "accept mid burst")
   `TWE_ASSERT_NOW(a_plain_empty, clock, reset, rsp_plain, rsp_plain_empty, "word on plain result")

endmodule

`default_nettype wire
